FILE: hw/rtl/rmod_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmod_pkg
// Shared widths, constants and types of the restarting mean onset detector.
// ----------------------------------------------------------------------------
package rmod_pkg;

	localparam int SAMPLE_W = 24;   // input sample, signed fixed point
	localparam int COUNT_W  = 16;   // averaging count and config registers
	localparam int NUM_W    = 40;   // magnitude of (n-1)*mean + sample
	localparam int SCALED_W = 38;   // scaled sample / scaled mean / change
	localparam int EXCESS_W = 37;   // clipped excess
	localparam int STEP_W   = $clog2(NUM_W);

	localparam int SCALE_FACTOR = 10000;
	localparam int SCALE_K_W    = 15;
	localparam int WIN_RESET    = 1000;
	localparam int RST_RESET    = 200;

	localparam int OUT_DATA_W = ((3 * SCALED_W + EXCESS_W + 7) / 8) * 8;

	// configuration register indexes
	localparam logic REG_WINDOW_LIMIT  = 1'b0;
	localparam logic REG_RESTART_COUNT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SCALE,
		ST_OUT
	} state_t;

endpackage : rmod_pkg
`default_nettype wire

FILE: hw/rtl/restarting_mean_onset_detector_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// restarting_mean_onset_detector_unit
// Cumulative mean of a feature stream with count restart, scaled excess output.
// ----------------------------------------------------------------------------
// Input stream s_*: one signed 24-bit sample per request in s_tdata.
// Output stream m_*: one result per sample, m_tdata fields scaled by 10000:
//   scaled sample, updated scaled mean, clipped excess and excess change.
// Config port wr_*: index 0 window limit, index 1 restart count; write only
//   while no sample is in flight.
// Each sample goes from input request to output valid in these steps: the
//   (count-1)*mean + sample product and divider load, the bit-serial divider
//   (one quotient bit per cycle) until done, the quotient taken as the new
//   mean with the scaling multiplies, and excess and output load. A new sample
//   is taken only after the last one's output load; s_tready is high only
//   between samples.
// The output register lets the next sample be taken while a result waits;
//   if m_tready stays low the block holds the following result before its
//   output load until the register frees.
// Reset clears count, mean and excess history and loads the config defaults
//   (window limit 1000, restart count 200).
// ----------------------------------------------------------------------------
module restarting_mean_onset_detector_unit
	import rmod_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// config write port
	input  wire logic                  wr_en,
	input  wire logic                  wr_index,
	input  wire logic [COUNT_W-1:0]    wr_data,
	// input stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [SAMPLE_W-1:0]   s_tdata,    // [23:0] sample
	// output stream
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata     // [37:0] scaled_sample,
	                                               // [75:38] scaled_mean,
	                                               // [112:76] excess,
	                                               // [150:113] excess_change
);

	localparam logic signed [SCALE_K_W-1:0] SCALE_K = SCALE_K_W'(SCALE_FACTOR);

	state_t state_q, state_d;

	logic [COUNT_W-1:0]         window_q;
	logic [COUNT_W-1:0]         restart_q;
	logic [COUNT_W-1:0]         count_q;
	logic signed [SAMPLE_W-1:0] mean_q;
	logic [EXCESS_W-1:0]        prev_q;
	logic [EXCESS_W-1:0]        prev2_q;
	logic                       m_tvalid_q;

	logic signed [SAMPLE_W-1:0] sample_q;
	logic [COUNT_W-1:0]         n_q;
	logic                       neg_q;
	logic signed [SCALED_W-1:0] ss_q;
	logic signed [SCALED_W-1:0] sm_q;
	logic [SCALED_W-1:0]        out_ss_q;
	logic [SCALED_W-1:0]        out_sm_q;
	logic [EXCESS_W-1:0]        out_ex_q;
	logic [SCALED_W-1:0]        out_chg_q;

	logic                       in_req;
	logic                       out_load;
	logic [COUNT_W:0]           count_inc;
	logic [COUNT_W-1:0]         count_next;

	logic [COUNT_W-1:0]         n_less;
	logic signed [NUM_W:0]      prod;
	logic signed [NUM_W:0]      num;
	logic [NUM_W:0]             num_mag;

	logic                       div_done;
	logic [SAMPLE_W-1:0]        quot;
	logic signed [SAMPLE_W-1:0] mean_new;
	logic signed [SAMPLE_W+SCALE_K_W-1:0] ss_full;
	logic signed [SAMPLE_W+SCALE_K_W-1:0] sm_full;

	logic [SCALED_W:0]          diff;
	logic [EXCESS_W-1:0]        ex;
	logic [SCALED_W-1:0]        chg;

	assign in_req   = s_tvalid && s_tready;
	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	// count restart; count + 1 is one bit wider so it never wraps
	assign count_inc  = {1'b0, count_q} + 1'b1;
	assign count_next = (count_inc >= {1'b0, window_q}) ? restart_q : count_inc[COUNT_W-1:0];

	// (n-1)*mean + sample, split into sign and magnitude for the divider
	assign n_less  = n_q - 1'b1;
	assign prod    = $signed({1'b0, n_less}) * mean_q;
	assign num     = prod + (NUM_W+1)'(sample_q);
	assign num_mag = num[NUM_W] ? -num : num;

	rmod_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_MUL),
		.dividend (num_mag[NUM_W-1:0]),
		.divisor  (n_q),
		.done     (div_done),
		.quotient (quot)
	);

	assign mean_new = neg_q ? -$signed(quot) : $signed(quot);
	assign ss_full  = sample_q * SCALE_K;
	assign sm_full  = mean_new * SCALE_K;

	// excess: clip below at zero and above at the 37-bit maximum
	assign diff = {ss_q[SCALED_W-1], ss_q} - {sm_q[SCALED_W-1], sm_q};
	always_comb begin
		if (diff[SCALED_W])
			ex = '0;
		else if (diff[EXCESS_W])
			ex = '1;
		else
			ex = diff[EXCESS_W-1:0];
	end
	assign chg = {1'b0, ex} - {1'b0, prev2_q};

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = ST_MUL;
			end
			ST_MUL:   state_d = ST_DIV;
			ST_DIV:   if (div_done) state_d = ST_SCALE;
			ST_SCALE: state_d = ST_OUT;
			ST_OUT:   if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			window_q   <= COUNT_W'(WIN_RESET);
			restart_q  <= COUNT_W'(RST_RESET);
			count_q    <= '0;
			mean_q     <= '0;
			prev_q     <= '0;
			prev2_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				case (wr_index)
					REG_WINDOW_LIMIT:  window_q  <= wr_data;
					REG_RESTART_COUNT: restart_q <= wr_data;
					default: ;
				endcase
			end
			if (in_req)
				count_q <= count_next;
			if (state_q == ST_SCALE)
				mean_q <= mean_new;
			if (out_load) begin
				prev2_q    <= prev_q;
				prev_q     <= ex;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_req) begin
			sample_q <= $signed(s_tdata);
			// a zero count divides as one
			n_q      <= (count_next == '0) ? COUNT_W'(1) : count_next;
		end
		if (state_q == ST_MUL)
			neg_q <= num[NUM_W];
		if (state_q == ST_SCALE) begin
			ss_q <= ss_full[SCALED_W-1:0];
			sm_q <= sm_full[SCALED_W-1:0];
		end
		if (out_load) begin
			out_ss_q  <= ss_q;
			out_sm_q  <= sm_q;
			out_ex_q  <= ex;
			out_chg_q <= chg;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W - 3*SCALED_W - EXCESS_W){1'b0}},
		out_chg_q, out_ex_q, out_sm_q, out_ss_q};

endmodule : restarting_mean_onset_detector_unit
`default_nettype wire

FILE: hw/rtl/rmod_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmod_div
// Bit-serial restoring divider: one quotient bit per cycle.
// Unsigned dividend by a non-zero unsigned divisor; quotient holds after done.
// ----------------------------------------------------------------------------
module rmod_div
	import rmod_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [NUM_W-1:0]    dividend,
	input  wire logic [COUNT_W-1:0]  divisor,
	output logic                     done,
	output logic [SAMPLE_W-1:0]      quotient
);

	logic               busy_q;
	logic               done_q;
	logic [STEP_W-1:0]  step_q;
	logic [NUM_W-1:0]   work_q;   // dividend shifts out, quotient shifts in
	logic [COUNT_W-1:0] rem_q;
	logic [COUNT_W-1:0] den_q;

	logic [COUNT_W:0]   trial;
	logic [COUNT_W:0]   trial_sub;
	logic               fits;

	assign trial     = {rem_q, work_q[NUM_W-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign fits      = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			den_q  <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the top bit drops safely
			rem_q  <= fits ? trial_sub[COUNT_W-1:0] : trial[COUNT_W-1:0];
			work_q <= {work_q[NUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = work_q[SAMPLE_W-1:0];

endmodule : rmod_div
`default_nettype wire
